FILE: hw/rtl/bpac_pkg.sv
// bpac_pkg: shared types, codes and reset constants for the button press classifier
// depends on nothing; imported by every module of the block
package bpac_pkg;

    // counter and threshold width
    localparam int unsigned CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // configuration port geometry
    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    // register reset values
    localparam logic [CNT_W-1:0] RST_GAIN_HOLD    = 16'd1000;
    localparam logic [CNT_W-1:0] RST_BALANCE_HOLD = 16'd1000;
    localparam logic [CNT_W-1:0] RST_SWITCH_HOLD  = 16'd2000;
    localparam logic [CNT_W-1:0] RST_LED_TIMEOUT  = 16'd5000;

    // operation codes carried in tuser
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_EVENT = 1'b1;

    typedef logic [CNT_W-1:0] t_cnt;

    // register index (paddr[3:2])
    typedef enum logic [1:0] {
        REG_GAIN_HOLD    = 2'd0,
        REG_BALANCE_HOLD = 2'd1,
        REG_SWITCH_HOLD  = 2'd2,
        REG_LED_TIMEOUT  = 2'd3
    } t_reg_idx;

    // button codes; none means no button held
    typedef enum logic [2:0] {
        BTN_TOP    = 3'd0,
        BTN_RIGHT  = 3'd1,
        BTN_BOTTOM = 3'd2,
        BTN_LEFT   = 3'd3,
        BTN_NONE   = 3'd4
    } t_btn;

    // action codes
    typedef enum logic [3:0] {
        ACT_LED_UP      = 4'd0,
        ACT_BRIGHT_UP   = 4'd1,
        ACT_LED_DOWN    = 4'd2,
        ACT_BRIGHT_DOWN = 4'd3,
        ACT_WHITE_BAL   = 4'd4,
        ACT_SNAPSHOT    = 4'd5,
        ACT_STOP_REC    = 4'd6,
        ACT_CAM_SWITCH  = 4'd7,
        ACT_PREP_REC    = 4'd8
    } t_action;

    typedef struct packed {
        t_cnt gain_hold;
        t_cnt balance_hold;
        t_cnt sw_hold;
        t_cnt led_timeout;
    } t_cfg;

    typedef struct packed {
        logic       op;
        logic [7:0] button_id;
        logic       pressed;
        logic       rec_active;
    } t_item;

    typedef struct packed {
        t_action action;
        logic    led_mode_now;
    } t_result;

endpackage

FILE: hw/rtl/bpac_cfg.sv
// bpac_cfg: apb register file holding hold thresholds and led mode timeout
// depends on bpac_pkg
module bpac_cfg
    import bpac_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output logic              o_pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    logic     wr_en;
    t_reg_idx idx;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign idx      = t_reg_idx'(i_paddr[3:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_hold    <= RST_GAIN_HOLD;
            r_cfg.balance_hold <= RST_BALANCE_HOLD;
            r_cfg.sw_hold      <= RST_SWITCH_HOLD;
            r_cfg.led_timeout  <= RST_LED_TIMEOUT;
        end else if (wr_en) begin
            case (idx)
                REG_GAIN_HOLD:    r_cfg.gain_hold    <= i_pwdata[CNT_W-1:0];
                REG_BALANCE_HOLD: r_cfg.balance_hold <= i_pwdata[CNT_W-1:0];
                REG_SWITCH_HOLD:  r_cfg.sw_hold      <= i_pwdata[CNT_W-1:0];
                REG_LED_TIMEOUT:  r_cfg.led_timeout  <= i_pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        o_prdata = '0;
        case (idx)
            REG_GAIN_HOLD:    o_prdata[CNT_W-1:0] = r_cfg.gain_hold;
            REG_BALANCE_HOLD: o_prdata[CNT_W-1:0] = r_cfg.balance_hold;
            REG_SWITCH_HOLD:  o_prdata[CNT_W-1:0] = r_cfg.sw_hold;
            REG_LED_TIMEOUT:  o_prdata[CNT_W-1:0] = r_cfg.led_timeout;
            default:          o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/bpac_core.sv
// bpac_core: press tracking state, hold and idle counters, and action decision
// depends on bpac_pkg; state advances on each word taken from the input register
module bpac_core
    import bpac_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_go,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output logic    o_res_valid,
    output t_result o_res
);

    t_btn r_held,      n_held;
    logic r_long_done, n_long_done;
    logic r_led_mode,  n_led_mode;
    t_cnt r_hold_cnt,  n_hold_cnt;
    t_cnt r_idle_cnt,  n_idle_cnt;

    t_cnt hold_inc;
    t_cnt idle_inc;
    t_cnt thr;
    t_btn ev_btn;
    logic fire;
    logic is_long;

    // saturating counter increments
    assign hold_inc = (r_hold_cnt == CNT_MAX) ? r_hold_cnt : r_hold_cnt + t_cnt'(1);
    assign idle_inc = (r_idle_cnt == CNT_MAX) ? r_idle_cnt : r_idle_cnt + t_cnt'(1);
    assign ev_btn   = t_btn'(i_item.button_id[2:0]);

    // long press threshold of the held button
    always_comb begin
        case (r_held)
            BTN_TOP, BTN_BOTTOM: thr = i_cfg.gain_hold;
            BTN_LEFT:            thr = i_cfg.balance_hold;
            default:             thr = i_cfg.sw_hold;
        endcase
    end

    // next state and result
    always_comb begin
        n_held      = r_held;
        n_long_done = r_long_done;
        n_led_mode  = r_led_mode;
        n_hold_cnt  = r_hold_cnt;
        n_idle_cnt  = r_idle_cnt;
        fire        = 1'b0;
        is_long     = 1'b0;
        o_res.action = ACT_LED_UP;

        if (i_item.op == OP_TICK) begin
            n_hold_cnt = hold_inc;
            n_idle_cnt = idle_inc;
            // led adjust mode timeout
            if (r_led_mode && (idle_inc > i_cfg.led_timeout)) begin
                n_led_mode = 1'b0;
            end
            // long press detection
            if ((r_held != BTN_NONE) && (hold_inc > thr)) begin
                fire        = 1'b1;
                is_long     = 1'b1;
                n_long_done = 1'b1;
                n_held      = BTN_NONE;
            end
        end else if (i_item.button_id[7:2] == 6'd0) begin
            if (i_item.pressed) begin
                n_hold_cnt  = '0;
                n_long_done = 1'b0;
                n_held      = ev_btn;
            end else if (ev_btn == r_held) begin
                if (r_long_done) begin
                    n_long_done = 1'b0;
                end else begin
                    fire   = 1'b1;
                    n_held = BTN_NONE;
                end
            end
        end

        // action of the button that fired
        if (fire) begin
            case (r_held)
                BTN_TOP: begin
                    n_led_mode = n_led_mode || is_long;
                    if (n_led_mode) begin
                        n_idle_cnt   = '0;
                        o_res.action = ACT_LED_UP;
                    end else begin
                        o_res.action = ACT_BRIGHT_UP;
                    end
                end
                BTN_BOTTOM: begin
                    n_led_mode = n_led_mode || is_long;
                    if (n_led_mode) begin
                        n_idle_cnt   = '0;
                        o_res.action = ACT_LED_DOWN;
                    end else begin
                        o_res.action = ACT_BRIGHT_DOWN;
                    end
                end
                BTN_LEFT: begin
                    o_res.action = is_long ? ACT_WHITE_BAL : ACT_SNAPSHOT;
                end
                BTN_RIGHT: begin
                    if (i_item.rec_active) begin
                        o_res.action = ACT_STOP_REC;
                    end else begin
                        o_res.action = is_long ? ACT_CAM_SWITCH : ACT_PREP_REC;
                    end
                end
                default: o_res.action = ACT_LED_UP;
            endcase
        end

        o_res.led_mode_now = n_led_mode;
        o_res_valid        = fire;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= BTN_NONE;
            r_long_done <= 1'b0;
            r_led_mode  <= 1'b0;
            r_hold_cnt  <= '0;
            r_idle_cnt  <= '0;
        end else if (i_go) begin
            r_held      <= n_held;
            r_long_done <= n_long_done;
            r_led_mode  <= n_led_mode;
            r_hold_cnt  <= n_hold_cnt;
            r_idle_cnt  <= n_idle_cnt;
        end
    end

endmodule

FILE: hw/rtl/button_press_action_classifier_core.sv
// button_press_action_classifier_core: top level with input word register and result register
// depends on bpac_pkg, bpac_cfg, bpac_core
//
//  channel   | direction | handshake          | content
//  ----------+-----------+--------------------+----------------------------------------
//  s_*       | in        | s_tvalid/s_tready  | tick or button event word
//  m_*       | out       | m_tvalid/m_tready  | action word, zero or one per input word
//  apb       | in        | psel/penable/pready| four 16-bit threshold/timeout registers
//
// one input word per cycle while s_tready is high; a word is held in the input register and its
// action is then registered in the result register, which drives the m side.
// synchronous active-low reset clears control and press state, registers reload defaults.
// a stalled m side holds the result; s_tready drops only while the result register
// is full, not taken, and the word in the input register would produce a new one.
module button_press_action_classifier_core
    import bpac_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,  // [7:0] button_id, [8] pressed, [9] recording_active
    input  logic              s_tuser,  // [0] operation
    // output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,  // [3:0] action, [4] led_mode_now
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg    cfg;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    go;
    logic    res_valid;
    t_result res;

    bpac_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    bpac_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_item      (r_in),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // the held word moves on when a result slot is free or it makes no result
    assign go       = r_in_valid && (!r_out_valid || m_tready || !res_valid);
    assign s_tready = !r_in_valid || go;

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in.op         <= s_tuser;
            r_in.button_id  <= s_tdata[7:0];
            r_in.pressed    <= s_tdata[8];
            r_in.rec_active <= s_tdata[9];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && res_valid) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {3'b000, r_out.led_mode_now, r_out.action};

endmodule
